FILE: rtl/mlptw_pkg.sv
// Package with the request and response types, codes and walker states of the page table walker.
package mlptw_pkg;

    // Request kinds.
    localparam logic KIND_TRANSLATE = 1'b0;
    localparam logic KIND_ALLOCATE  = 1'b1;

    // Response status codes.
    localparam logic [1:0] STATUS_OK        = 2'd0;
    localparam logic [1:0] STATUS_UNMAPPED  = 2'd1;
    localparam logic [1:0] STATUS_NO_FRAMES = 2'd2;

    // Fixed field widths of the channels.
    localparam int VA_WIDTH = 48;
    localparam int PA_WIDTH = 20;

    typedef struct packed {
        logic                kind;
        logic [VA_WIDTH-1:0] virtual_address;
    } walk_req_t;

    typedef struct packed {
        logic [PA_WIDTH-1:0] physical_address;
        logic [1:0]          status;
    } walk_rsp_t;

    // Strobes that the walker gives to the table memory.
    typedef struct packed {
        logic rd_en;
        logic wr_en;
    } ram_ctl_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_READ,
        ST_CHECK,
        ST_RESP
    } walk_state_t;

endpackage

FILE: rtl/mlptw_table_ram.sv
// Single-port-write, single-port-read table memory with a registered read.
module mlptw_table_ram #(
    parameter int ADDR_WIDTH = 17,
    parameter int DATA_WIDTH = 9
) (
    input  logic                  aclk,
    input  logic                  wr_en,
    input  logic [ADDR_WIDTH-1:0] wr_addr,
    input  logic [DATA_WIDTH-1:0] wr_data,
    input  logic                  rd_en,
    input  logic [ADDR_WIDTH-1:0] rd_addr,
    output logic [DATA_WIDTH-1:0] rd_data
);

    logic [DATA_WIDTH-1:0] mem [2**ADDR_WIDTH];
    logic [DATA_WIDTH-1:0] rd_data_reg;

    // Write port.
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Registered read port.
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

FILE: rtl/mlptw_frame_alloc.sv
// Bump frame allocator: hands out frames in increasing order until none are left.
module mlptw_frame_alloc #(
    parameter int FRAME_COUNT = 256
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           take,
    output logic                           avail,
    output logic [$clog2(FRAME_COUNT)-1:0] frame
);

    localparam int FW = $clog2(FRAME_COUNT);

    logic [FW:0] next_free_reg;
    logic [FW:0] next_free_next;

    // The counter is one bit wider so that it can hold the frame count itself.
    assign avail = (next_free_reg < (FW + 1)'(FRAME_COUNT));
    assign frame = next_free_reg[FW-1:0];

    always_comb begin
        next_free_next = next_free_reg;
        if (take && avail) begin
            next_free_next = next_free_reg + (FW + 1)'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            next_free_reg <= '0;
        end else begin
            next_free_reg <= next_free_next;
        end
    end

endmodule

FILE: rtl/mlptw_walk_ctrl.sv
// Walk sequencer: steps through the levels, one table read and check per level.
module mlptw_walk_ctrl #(
    parameter int OFFSET_BITS = 12,
    parameter int LEVEL_COUNT = 4,
    parameter int FRAME_COUNT = 256
) (
    input  logic                                           aclk,
    input  logic                                           aresetn,
    input  logic                                           sweep_busy,
    input  logic                                           s_valid,
    output logic                                           s_ready,
    input  mlptw_pkg::walk_req_t                           s_req,
    output logic                                           m_valid,
    input  logic                                           m_ready,
    output mlptw_pkg::walk_rsp_t                           m_rsp,
    output mlptw_pkg::ram_ctl_t                            ram_ctl,
    output logic [$clog2(FRAME_COUNT)+OFFSET_BITS-4:0]     ram_addr,
    output logic [$clog2(FRAME_COUNT):0]                   ram_wdata,
    input  logic [$clog2(FRAME_COUNT):0]                   ram_rdata,
    input  logic                                           alloc_avail,
    input  logic [$clog2(FRAME_COUNT)-1:0]                 alloc_frame,
    output logic                                           alloc_take
);

    localparam int FW       = $clog2(FRAME_COUNT);
    localparam int IDX_BITS = OFFSET_BITS - 3;
    localparam int LW       = LEVEL_COUNT * IDX_BITS;
    localparam int LVW      = (LEVEL_COUNT > 1) ? $clog2(LEVEL_COUNT) : 1;

    mlptw_pkg::walk_state_t state_reg, state_next;
    logic                   kind_reg, kind_next;
    logic [LW-1:0]          idx_vec_reg, idx_vec_next;
    logic [OFFSET_BITS-1:0] offset_reg, offset_next;
    logic [FW-1:0]          table_reg, table_next;
    logic [LVW-1:0]         level_reg, level_next;
    logic [FW-1:0]          root_frame_reg, root_frame_next;
    logic                   root_present_reg, root_present_next;
    mlptw_pkg::walk_rsp_t   rsp_reg, rsp_next;

    logic                   entry_valid;
    logic [FW-1:0]          child_frame;
    logic [FW+OFFSET_BITS-1:0] pa_full;

    // The current level's index always sits at the top of the index vector.
    assign ram_addr    = {table_reg, idx_vec_reg[LW-1 -: IDX_BITS]};
    assign ram_wdata   = {alloc_frame, 1'b1};
    assign entry_valid = ram_rdata[0];
    assign child_frame = entry_valid ? ram_rdata[FW:1] : alloc_frame;
    assign pa_full     = {child_frame, offset_reg};

    assign s_ready = (state_reg == mlptw_pkg::ST_IDLE) && !sweep_busy;
    assign m_valid = (state_reg == mlptw_pkg::ST_RESP);
    assign m_rsp   = rsp_reg;

    // Next state and datapath control.
    always_comb begin
        state_next        = state_reg;
        kind_next         = kind_reg;
        idx_vec_next      = idx_vec_reg;
        offset_next       = offset_reg;
        table_next        = table_reg;
        level_next        = level_reg;
        root_frame_next   = root_frame_reg;
        root_present_next = root_present_reg;
        rsp_next          = rsp_reg;
        ram_ctl           = '0;
        alloc_take        = 1'b0;

        case (state_reg)
            mlptw_pkg::ST_IDLE: begin
                if (s_valid && s_ready) begin
                    kind_next    = s_req.kind;
                    offset_next  = s_req.virtual_address[OFFSET_BITS-1:0];
                    idx_vec_next = LW'(s_req.virtual_address >> OFFSET_BITS);
                    level_next   = '0;
                    if (root_present_reg) begin
                        table_next = root_frame_reg;
                        state_next = mlptw_pkg::ST_READ;
                    end else if (s_req.kind == mlptw_pkg::KIND_TRANSLATE) begin
                        rsp_next   = '{physical_address: '0,
                                       status: mlptw_pkg::STATUS_UNMAPPED};
                        state_next = mlptw_pkg::ST_RESP;
                    end else if (!alloc_avail) begin
                        rsp_next   = '{physical_address: '0,
                                       status: mlptw_pkg::STATUS_NO_FRAMES};
                        state_next = mlptw_pkg::ST_RESP;
                    end else begin
                        // First allocation creates the root table.
                        alloc_take        = 1'b1;
                        root_frame_next   = alloc_frame;
                        root_present_next = 1'b1;
                        table_next        = alloc_frame;
                        state_next        = mlptw_pkg::ST_READ;
                    end
                end
            end

            mlptw_pkg::ST_READ: begin
                ram_ctl.rd_en = 1'b1;
                state_next    = mlptw_pkg::ST_CHECK;
            end

            mlptw_pkg::ST_CHECK: begin
                if (!entry_valid && kind_reg == mlptw_pkg::KIND_TRANSLATE) begin
                    rsp_next   = '{physical_address: '0,
                                   status: mlptw_pkg::STATUS_UNMAPPED};
                    state_next = mlptw_pkg::ST_RESP;
                end else if (!entry_valid && !alloc_avail) begin
                    // Tables created so far stay in place.
                    rsp_next   = '{physical_address: '0,
                                   status: mlptw_pkg::STATUS_NO_FRAMES};
                    state_next = mlptw_pkg::ST_RESP;
                end else begin
                    if (!entry_valid) begin
                        alloc_take    = 1'b1;
                        ram_ctl.wr_en = 1'b1;
                    end
                    if (level_reg == LVW'(LEVEL_COUNT - 1)) begin
                        rsp_next   = '{physical_address: mlptw_pkg::PA_WIDTH'(pa_full),
                                       status: mlptw_pkg::STATUS_OK};
                        state_next = mlptw_pkg::ST_RESP;
                    end else begin
                        table_next   = child_frame;
                        level_next   = level_reg + LVW'(1);
                        idx_vec_next = idx_vec_reg << IDX_BITS;
                        state_next   = mlptw_pkg::ST_READ;
                    end
                end
            end

            mlptw_pkg::ST_RESP: begin
                if (m_ready) begin
                    state_next = mlptw_pkg::ST_IDLE;
                end
            end

            default: begin
                state_next = mlptw_pkg::ST_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg        <= mlptw_pkg::ST_IDLE;
            root_frame_reg   <= '0;
            root_present_reg <= 1'b0;
        end else begin
            state_reg        <= state_next;
            root_frame_reg   <= root_frame_next;
            root_present_reg <= root_present_next;
        end
    end

    // Walk payload registers.
    always_ff @(posedge aclk) begin
        kind_reg    <= kind_next;
        idx_vec_reg <= idx_vec_next;
        offset_reg  <= offset_next;
        table_reg   <= table_next;
        level_reg   <= level_next;
        rsp_reg     <= rsp_next;
    end

endmodule

FILE: rtl/multi_level_page_table_walker_core.sv
// Top level of the page table walker: memory clearing sweep and port muxing.
// Each request is taken in ST_IDLE and walks one ST_READ and one ST_CHECK state per level;
// its response then waits in ST_RESP until taken, and with no walk it goes straight there.
// One request at a time: a new one is taken only after the response has been accepted.
// Reset: synchronous, active low; afterwards the table memory is swept to zero, one entry
// per cycle, FRAME_COUNT * 2^(OFFSET_BITS-3) entries (131072 by default) before s_ready rises.
module multi_level_page_table_walker_core #(
    parameter int OFFSET_BITS = 12,
    parameter int LEVEL_COUNT = 4,
    parameter int FRAME_COUNT = 256
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  mlptw_pkg::walk_req_t s_req,
    output logic                 m_valid,
    input  logic                 m_ready,
    output mlptw_pkg::walk_rsp_t m_rsp
);

    localparam int FW          = $clog2(FRAME_COUNT);
    localparam int IDX_BITS    = OFFSET_BITS - 3;
    localparam int AW          = FW + IDX_BITS;
    localparam int EW          = FW + 1;
    localparam int CLEAR_DEPTH = FRAME_COUNT * (2 ** IDX_BITS);
    localparam logic [AW-1:0] CLEAR_LAST = AW'(CLEAR_DEPTH - 1);

    logic          clr_busy_reg, clr_busy_next;
    logic [AW-1:0] clr_addr_reg, clr_addr_next;

    mlptw_pkg::ram_ctl_t walk_ram_ctl;
    logic [AW-1:0]       walk_addr;
    logic [EW-1:0]       walk_wdata;
    logic [EW-1:0]       ram_rdata;
    logic                ram_wr_en;
    logic [AW-1:0]       ram_wr_addr;
    logic [EW-1:0]       ram_wr_data;
    logic                alloc_avail;
    logic [FW-1:0]       alloc_frame;
    logic                alloc_take;

    // Clearing sweep after reset.
    always_comb begin
        clr_busy_next = clr_busy_reg;
        clr_addr_next = clr_addr_reg;
        if (clr_busy_reg) begin
            clr_addr_next = clr_addr_reg + AW'(1);
            if (clr_addr_reg == CLEAR_LAST) begin
                clr_busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_busy_reg <= 1'b1;
            clr_addr_reg <= '0;
        end else begin
            clr_busy_reg <= clr_busy_next;
            clr_addr_reg <= clr_addr_next;
        end
    end

    // The sweep owns the write port until it is done.
    assign ram_wr_en   = clr_busy_reg || walk_ram_ctl.wr_en;
    assign ram_wr_addr = clr_busy_reg ? clr_addr_reg : walk_addr;
    assign ram_wr_data = clr_busy_reg ? '0 : walk_wdata;

    mlptw_table_ram #(
        .ADDR_WIDTH (AW),
        .DATA_WIDTH (EW)
    ) u_table_ram (
        .aclk    (aclk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_en   (walk_ram_ctl.rd_en),
        .rd_addr (walk_addr),
        .rd_data (ram_rdata)
    );

    mlptw_frame_alloc #(
        .FRAME_COUNT (FRAME_COUNT)
    ) u_frame_alloc (
        .aclk    (aclk),
        .aresetn (aresetn),
        .take    (alloc_take),
        .avail   (alloc_avail),
        .frame   (alloc_frame)
    );

    mlptw_walk_ctrl #(
        .OFFSET_BITS (OFFSET_BITS),
        .LEVEL_COUNT (LEVEL_COUNT),
        .FRAME_COUNT (FRAME_COUNT)
    ) u_walk_ctrl (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .sweep_busy  (clr_busy_reg),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_req       (s_req),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_rsp       (m_rsp),
        .ram_ctl     (walk_ram_ctl),
        .ram_addr    (walk_addr),
        .ram_wdata   (walk_wdata),
        .ram_rdata   (ram_rdata),
        .alloc_avail (alloc_avail),
        .alloc_frame (alloc_frame),
        .alloc_take  (alloc_take)
    );

endmodule

FILE: rtl/mlptw_checker.sv
// Port-level checker for the page table walker, bound to the top level.
module mlptw_checker (
    input logic                 aclk,
    input logic                 aresetn,
    input logic                 s_valid,
    input logic                 s_ready,
    input logic                 m_valid,
    input logic                 m_ready,
    input mlptw_pkg::walk_rsp_t m_rsp
);

    // A pending response holds until it is taken.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_rsp))
        else $error("response dropped or changed while stalled");

    // Only one request is in flight: no acceptance while a response waits.
    assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_ready && m_valid))
        else $error("request accepted while a response is pending");

    // Once a request is taken the walker is busy in the next cycle.
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("walker ready straight after accepting a request");

    // A failed request reports a zero address.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_rsp.status != mlptw_pkg::STATUS_OK |-> m_rsp.physical_address == '0)
        else $error("non-zero address with an error status");

    // Only defined status codes appear.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_rsp.status == mlptw_pkg::STATUS_OK
                     || m_rsp.status == mlptw_pkg::STATUS_UNMAPPED
                     || m_rsp.status == mlptw_pkg::STATUS_NO_FRAMES))
        else $error("undefined status code");

endmodule

bind multi_level_page_table_walker_core mlptw_checker u_mlptw_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_valid (s_valid),
    .s_ready (s_ready),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_rsp   (m_rsp)
);

FILE: tb/testbench.sv
// Self-checking testbench for the multi-level page table walker core.
`timescale 1ns / 1ps

module testbench;

    localparam int OFFSET_BITS   = 12;
    localparam int LEVEL_COUNT   = 4;
    localparam int FRAME_COUNT   = 256;
    localparam int IDX_BITS      = OFFSET_BITS - 3;
    localparam int TABLE_ENTRIES = 1 << IDX_BITS;
    localparam int CYCLE_LIMIT   = 500000;
    localparam int HOLD_AT       = 200;
    localparam int HOLD_CYCLES   = 300;

    logic                 aclk    = 1'b0;
    logic                 aresetn = 1'b0;
    logic                 s_valid = 1'b0;
    logic                 s_ready;
    mlptw_pkg::walk_req_t s_req   = '0;
    logic                 m_valid;
    logic                 m_ready = 1'b0;
    mlptw_pkg::walk_rsp_t m_rsp;

    // Requests waiting to be offered and responses waiting to be seen.
    mlptw_pkg::walk_req_t pending_reqs[$];
    mlptw_pkg::walk_rsp_t expected_rsps[$];

    // Shadow of the walker: table memory, root table and frame allocator.
    logic [8:0]  shadow_tables [0:FRAME_COUNT*TABLE_ENTRIES-1];
    logic [7:0]  shadow_root;
    bit          shadow_root_ok;
    int unsigned shadow_next_frame;

    // Small pools of indices per level, so that walks share their upper tables.
    logic [IDX_BITS-1:0] index_pool [0:LEVEL_COUNT-1][0:3];

    int unsigned cycle_count = 0;
    int unsigned mismatch_count = 0;
    int unsigned req_count = 0;
    int unsigned rsp_count = 0;
    int unsigned gap_left = 0;
    int unsigned stall_left = 0;
    int unsigned hold_left = 0;
    bit          hold_used = 1'b0;
    bit          send_burst = 1'b0;
    bit          recv_burst = 1'b0;

    multi_level_page_table_walker_core #(
        .OFFSET_BITS(OFFSET_BITS),
        .LEVEL_COUNT(LEVEL_COUNT),
        .FRAME_COUNT(FRAME_COUNT)
    ) i_dut (
        .aclk   (aclk),
        .aresetn(aresetn),
        .s_valid(s_valid),
        .s_ready(s_ready),
        .s_req  (s_req),
        .m_valid(m_valid),
        .m_ready(m_ready),
        .m_rsp  (m_rsp)
    );

    always #5 aclk = ~aclk;

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
    end

    // Hands out the next frame and clears it as a fresh table; fails when none are left.
    function automatic bit grab_frame(output int unsigned frame);
        if (shadow_next_frame >= FRAME_COUNT) begin
            return 1'b0;
        end
        frame = shadow_next_frame;
        shadow_next_frame++;
        for (int e = 0; e < TABLE_ENTRIES; e++) begin
            shadow_tables[frame*TABLE_ENTRIES + e] = '0;
        end
        return 1'b1;
    endfunction

    // Walks the shadow tables for one request, creating tables when allocating.
    function automatic mlptw_pkg::walk_rsp_t predict_walk(input mlptw_pkg::walk_req_t req);
        mlptw_pkg::walk_rsp_t rsp;
        logic [63:0]          va;
        int unsigned          tbl;
        int unsigned          frame;
        int unsigned          idx;
        logic [8:0]           entry;
        rsp.physical_address = '0;
        rsp.status = mlptw_pkg::STATUS_OK;
        va = 64'(req.virtual_address);
        if (!shadow_root_ok) begin
            if (req.kind == mlptw_pkg::KIND_TRANSLATE) begin
                rsp.status = mlptw_pkg::STATUS_UNMAPPED;
                return rsp;
            end
            if (!grab_frame(frame)) begin
                rsp.status = mlptw_pkg::STATUS_NO_FRAMES;
                return rsp;
            end
            shadow_root = frame[7:0];
            shadow_root_ok = 1'b1;
        end
        tbl = shadow_root;
        frame = 0;
        for (int lvl = 0; lvl < LEVEL_COUNT; lvl++) begin
            // A shift past the address width leaves an index of zero.
            idx = 32'((va >> (OFFSET_BITS + (LEVEL_COUNT - 1 - lvl) * IDX_BITS))
                      & (TABLE_ENTRIES - 1));
            entry = shadow_tables[tbl*TABLE_ENTRIES + idx];
            if (!entry[0]) begin
                if (req.kind == mlptw_pkg::KIND_TRANSLATE) begin
                    rsp.status = mlptw_pkg::STATUS_UNMAPPED;
                    return rsp;
                end
                if (!grab_frame(frame)) begin
                    rsp.status = mlptw_pkg::STATUS_NO_FRAMES;
                    return rsp;
                end
                entry = {frame[7:0], 1'b1};
                shadow_tables[tbl*TABLE_ENTRIES + idx] = entry;
            end
            frame = entry[8:1];
            tbl = frame;
        end
        rsp.physical_address = mlptw_pkg::PA_WIDTH'((64'(frame) << OFFSET_BITS)
                                         | (va & ((64'd1 << OFFSET_BITS) - 1)));
        return rsp;
    endfunction

    function automatic int unsigned draw_wait(input bit burst);
        return burst ? 0 : $urandom_range(0, 11);
    endfunction

    function automatic void queue_req(input logic kind,
                                      input logic [mlptw_pkg::VA_WIDTH-1:0] va);
        mlptw_pkg::walk_req_t req;
        req.kind = kind;
        req.virtual_address = va;
        pending_reqs.push_back(req);
    endfunction

    // Address built from the index pools with a random page offset.
    function automatic logic [mlptw_pkg::VA_WIDTH-1:0] cluster_va();
        logic [mlptw_pkg::VA_WIDTH-1:0] va;
        va = '0;
        for (int lvl = 0; lvl < LEVEL_COUNT; lvl++) begin
            va[mlptw_pkg::VA_WIDTH-1-lvl*IDX_BITS -: IDX_BITS] =
                index_pool[lvl][$urandom_range(0, 3)];
        end
        va[OFFSET_BITS-1:0] = OFFSET_BITS'($urandom);
        return va;
    endfunction

    function automatic logic [mlptw_pkg::VA_WIDTH-1:0] wide_va();
        return {16'($urandom), 32'($urandom)};
    endfunction

    // Request driver: offers queued requests with random gaps and predicts each accepted one.
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
            gap_left = 0;
            shadow_root_ok = 1'b0;
            shadow_root = '0;
            shadow_next_frame = 0;
        end else begin
            if (s_valid && s_ready) begin
                expected_rsps.push_back(predict_walk(s_req));
                req_count++;
            end
            if (s_valid && !s_ready) begin
                // Hold the request until it is taken.
            end else if (gap_left != 0) begin
                s_valid <= 1'b0;
                gap_left--;
            end else if (pending_reqs.size() != 0) begin
                s_valid <= 1'b1;
                s_req <= pending_reqs.pop_front();
                if ($urandom_range(0, 24) == 0) begin
                    send_burst = ~send_burst;
                end
                gap_left = draw_wait(send_burst);
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // One long hold-off of the receiver, so that the walker backs up and refuses requests.
    always @(posedge aclk) begin
        if (!aresetn) begin
            hold_left <= 0;
        end else if (!hold_used && rsp_count == HOLD_AT) begin
            hold_left <= HOLD_CYCLES;
            hold_used <= 1'b1;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
        end
    end

    // Response monitor: checks each accepted response and stalls at random.
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
            stall_left = 0;
        end else begin
            if (m_valid && m_ready) begin
                if (expected_rsps.size() == 0) begin
                    mismatch_count++;
                    if (mismatch_count <= 10) begin
                        $display("response %0d with no request outstanding: pa %h status %0d",
                                 rsp_count, m_rsp.physical_address, m_rsp.status);
                    end
                end else begin
                    mlptw_pkg::walk_rsp_t want;
                    want = expected_rsps.pop_front();
                    if (m_rsp.physical_address !== want.physical_address
                        || m_rsp.status !== want.status) begin
                        mismatch_count++;
                        if (mismatch_count <= 10) begin
                            $display({"response %0d: expected pa %h status %0d, ",
                                      "got pa %h status %0d"},
                                     rsp_count, want.physical_address, want.status,
                                     m_rsp.physical_address, m_rsp.status);
                        end
                    end
                end
                rsp_count++;
                if ($urandom_range(0, 24) == 0) begin
                    recv_burst = ~recv_burst;
                end
                stall_left = draw_wait(recv_burst);
            end else if (stall_left != 0) begin
                stall_left--;
            end
            m_ready <= (stall_left == 0 && hold_left == 0);
        end
    end

    initial begin : stimulus
        logic [mlptw_pkg::VA_WIDTH-1:0] va;
        logic [mlptw_pkg::VA_WIDTH-1:0] mapped_pages[$];
        int unsigned pick;

        for (int lvl = 0; lvl < LEVEL_COUNT; lvl++) begin
            index_pool[lvl][0] = '0;
            index_pool[lvl][1] = '1;
            index_pool[lvl][2] = IDX_BITS'($urandom);
            index_pool[lvl][3] = IDX_BITS'($urandom);
        end

        // Directed: no root table, address extremes, repeated allocation and
        // misses at each level of the walk.
        queue_req(mlptw_pkg::KIND_TRANSLATE, '0);
        queue_req(mlptw_pkg::KIND_TRANSLATE, '1);
        queue_req(mlptw_pkg::KIND_ALLOCATE, '0);
        queue_req(mlptw_pkg::KIND_TRANSLATE, '0);
        queue_req(mlptw_pkg::KIND_TRANSLATE, 48'h0000_0000_0FFF);
        queue_req(mlptw_pkg::KIND_ALLOCATE, '1);
        queue_req(mlptw_pkg::KIND_TRANSLATE, '1);
        queue_req(mlptw_pkg::KIND_ALLOCATE, 48'h0000_0000_0ABC);
        queue_req(mlptw_pkg::KIND_TRANSLATE, 48'h0000_0000_1000);
        queue_req(mlptw_pkg::KIND_TRANSLATE, 48'h0080_0000_0000);
        queue_req(mlptw_pkg::KIND_TRANSLATE, 48'h0000_4000_0000);
        queue_req(mlptw_pkg::KIND_TRANSLATE, 48'h0000_0020_0000);
        queue_req(mlptw_pkg::KIND_ALLOCATE, 48'h0000_0020_0ABC);
        queue_req(mlptw_pkg::KIND_TRANSLATE, 48'h0000_0020_0123);

        // Random: mostly allocations and look-ups inside a clustered address
        // space, with some wide addresses as noise.
        for (int n = 0; n < 600; n++) begin
            pick = $urandom_range(0, 99);
            if (pick < 30) begin
                va = cluster_va();
                mapped_pages.push_back(va);
                queue_req(mlptw_pkg::KIND_ALLOCATE, va);
            end else if (pick < 60 && mapped_pages.size() != 0) begin
                va = mapped_pages[$urandom_range(0, mapped_pages.size() - 1)];
                va[OFFSET_BITS-1:0] = OFFSET_BITS'($urandom);
                queue_req(mlptw_pkg::KIND_TRANSLATE, va);
            end else if (pick < 85) begin
                queue_req(mlptw_pkg::KIND_TRANSLATE, cluster_va());
            end else if (pick < 97) begin
                queue_req(mlptw_pkg::KIND_TRANSLATE, wide_va());
            end else begin
                queue_req(mlptw_pkg::KIND_ALLOCATE, wide_va());
            end
        end

        // Wide allocations drain the frame allocator, then look-ups and allocations of mapped pages follow.
        for (int n = 0; n < 40; n++) begin
            queue_req(mlptw_pkg::KIND_ALLOCATE, wide_va());
        end
        for (int n = 0; n < 10; n++) begin
            va = mapped_pages[$urandom_range(0, mapped_pages.size() - 1)];
            queue_req(n % 2 ? mlptw_pkg::KIND_ALLOCATE : mlptw_pkg::KIND_TRANSLATE, va);
        end

        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;

        fork
            begin
                while (!(aresetn && pending_reqs.size() == 0 && !s_valid
                         && expected_rsps.size() == 0)) begin
                    @(posedge aclk);
                end
                repeat (20) @(posedge aclk);
            end
            wait (cycle_count >= CYCLE_LIMIT);
        join_any

        if (cycle_count < CYCLE_LIMIT && mismatch_count == 0 && expected_rsps.size() == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule
